// ===== sv/kpu_pkg.sv =====
// shared types, constants and the factorial table for the permutation unranker
package kpu_pkg;

   localparam int unsigned MaxDigitsDefault = 9;
   localparam int unsigned DigitW = 4;
   localparam int unsigned RankW  = 19;

   typedef struct packed {
      logic [DigitW-1:0] perm_length;
      logic [RankW-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic [DigitW-1:0] digit;
      logic              last;
      logic              error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic init;
      logic step;
      logic fail;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic final_digit;
   } sts_type;

   function automatic logic [RankW-1:0] fact_value(input logic [DigitW-1:0] n);
      logic [RankW-1:0] f;
      unique case (n)
         4'd0:    f = 19'd1;
         4'd1:    f = 19'd1;
         4'd2:    f = 19'd2;
         4'd3:    f = 19'd6;
         4'd4:    f = 19'd24;
         4'd5:    f = 19'd120;
         4'd6:    f = 19'd720;
         4'd7:    f = 19'd5040;
         4'd8:    f = 19'd40320;
         4'd9:    f = 19'd362880;
         default: f = 19'h7FFFF;
      endcase
      return f;
   endfunction

endpackage

// ===== sv/kpu_dp.sv =====
// datapath: input latch, remaining rank, digit pool and result register
module kpu_dp #(
   parameter int unsigned MAX_DIGITS = kpu_pkg::MaxDigitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  kpu_pkg::req_type  req_data,
   input  kpu_pkg::cmd_type  cmd,
   output kpu_pkg::sts_type  sts,
   output logic              rsp_strobe,
   output kpu_pkg::rsp_type  rsp_data
);

   localparam int unsigned DW   = kpu_pkg::DigitW;
   localparam int unsigned RW   = kpu_pkg::RankW;
   localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [DW-1:0]    len_ff, len_in;
   logic [RW-1:0]    rank_ff, rank_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    pos_ff, pos_in;
   logic [DW-1:0]    pool_ff [MAX_DIGITS];
   logic [DW-1:0]    pool_in [MAX_DIGITS];
   kpu_pkg::rsp_type rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic [RW-1:0]    fact_sel;
   logic [IdxW-1:0]  idx;
   logic [RW-1:0]    prod;
   logic [DW-1:0]    pick;

   // quotient of remaining rank by (pos-1)! from parallel compares against its multiples
   always_comb begin
      fact_sel = kpu_pkg::fact_value(pos_ff - 4'd1);
      idx      = '0;
      prod     = '0;
      for (int j = 1; j < MAX_DIGITS; j++) begin
         if (rem_ff >= RW'(fact_sel * RW'(j))) begin
            idx  = IdxW'(j);
            prod = RW'(fact_sel * RW'(j));
         end
      end
   end

   assign pick = pool_ff[idx];

   assign sts.bad = (len_ff == '0) || (len_ff > DW'(MAX_DIGITS)) || (rank_ff == '0) ||
                    (rank_ff > kpu_pkg::fact_value(len_ff));
   assign sts.final_digit = (pos_ff == 4'd1);

   always_comb begin
      len_in    = len_ff;
      rank_in   = rank_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      pool_in   = pool_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      if (cmd.load) begin
         len_in  = req_data.perm_length;
         rank_in = req_data.rank;
      end
      if (cmd.init) begin
         rem_in = rank_ff - 19'd1;
         pos_in = len_ff;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            pool_in[i] = DW'(i + 1);
         end
      end
      if (cmd.step) begin
         rem_in = rem_ff - prod;
         pos_in = pos_ff - 4'd1;
         // close the gap left by the picked digit
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            if (IdxW'(i) >= idx) begin
               pool_in[i] = pool_ff[i + 1];
            end
         end
         pool_in[MAX_DIGITS-1] = '0;
         rsp_in.digit = pick;
         rsp_in.last  = (pos_ff == 4'd1);
         rsp_in.error = 1'b0;
         strobe_in    = 1'b1;
      end
      if (cmd.fail) begin
         rsp_in.digit = '0;
         rsp_in.last  = 1'b1;
         rsp_in.error = 1'b1;
         strobe_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      rank_ff <= rank_in;
      rem_ff  <= rem_in;
      pos_ff  <= pos_in;
      pool_ff <= pool_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.error |-> rsp_ff.last)
      else $error("error item not marked last");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.last |=> !strobe_ff)
      else $error("item emitted right after a last item");

   a_pick_in_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (DW'(idx) < pos_ff))
      else $error("digit index beyond remaining pool");
`endif

endmodule

// ===== sv/kpu_ctrl.sv =====
// controller: sequences check, pool setup and one digit per cycle
module kpu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kpu_pkg::sts_type sts,
   output kpu_pkg::cmd_type cmd,
   output logic             busy
);

   kpu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kpu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         kpu_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = kpu_pkg::ST_CHECK;
            end
         end
         kpu_pkg::ST_CHECK: begin
            if (sts.bad) begin
               cmd.fail = 1'b1;
               state_in = kpu_pkg::ST_IDLE;
            end else begin
               cmd.init = 1'b1;
               state_in = kpu_pkg::ST_RUN;
            end
         end
         kpu_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.final_digit) begin
               state_in = kpu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpu_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kpu_pkg::ST_IDLE) && start |=> (state_ff == kpu_pkg::ST_CHECK))
      else $error("accepted item did not enter check");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kpu_pkg::ST_RUN) && sts.final_digit |=> (state_ff == kpu_pkg::ST_IDLE))
      else $error("run did not end after final digit");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule

// ===== sv/kth_permutation_unrank.sv =====
// Unranks a one-based rank k into the k-th lexicographic permutation of 1..n.
// An item is taken when start is high and busy is low. After that the
// request is checked (n in 1..MAX_DIGITS, k in 1..n!); a bad request gives a
// single error item in the next cycle, otherwise the n digits follow on
// consecutive cycles, one per cycle from the digit-select step (remaining rank
// against multiples of a factorial table entry), the last one flagged. busy
// falls in the cycle after the last item is registered, so a new item is taken
// only once the previous one is finished. rsp_strobe marks each item for one
// cycle and there is no backpressure on the result side.
module kth_permutation_unrank #(
   parameter int unsigned MAX_DIGITS = kpu_pkg::MaxDigitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kpu_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output kpu_pkg::rsp_type rsp_data
);

   kpu_pkg::cmd_type cmd;
   kpu_pkg::sts_type sts;

   kpu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   kpu_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the permutation unranker: directed edge cases, then random traffic
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned MaxLen = kpu_pkg::MaxDigitsDefault;
   localparam int unsigned StallLimit = 1000;
   localparam int unsigned DrainCycles = 30;

   // n! for n = 0..9
   localparam int unsigned FactOf [10] = '{1, 1, 2, 6, 24, 120, 720, 5040, 40320, 362880};

   logic             clock;
   logic             reset;
   logic             start;
   kpu_pkg::req_type req_data;
   logic             busy;
   logic             rsp_strobe;
   kpu_pkg::rsp_type rsp_data;

   kpu_pkg::rsp_type pending_digits[$];
   int unsigned      mismatch_count;
   int unsigned      idle_cycles;
   int unsigned      burst_left;

   kth_permutation_unrank #(
      .MAX_DIGITS(MaxLen)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // factorial-base unranking of one request into its expected digit items
   function automatic void unrank_expected(input kpu_pkg::req_type item);
      int unsigned len;
      int unsigned remaining;
      int unsigned idx;
      int unsigned f;
      int unsigned pool[$];
      kpu_pkg::rsp_type r;
      len = item.perm_length;
      if (len == 0 || len > MaxLen || len > 9 || item.rank == 0 || item.rank > FactOf[len]) begin
         r = '{digit: '0, last: 1'b1, error: 1'b1};
         pending_digits.push_back(r);
         return;
      end
      for (int unsigned i = 1; i <= len; i++) pool.push_back(i);
      remaining = item.rank - 1;
      for (int unsigned pos = len; pos > 0; pos--) begin
         f = FactOf[pos-1];
         idx = remaining / f;
         remaining = remaining % f;
         if (idx >= pool.size()) idx = pool.size() - 1;
         r.digit = pool[idx][kpu_pkg::DigitW-1:0];
         r.last  = (pos == 1);
         r.error = 1'b0;
         pool.delete(idx);
         pending_digits.push_back(r);
      end
   endfunction

   // drive one item, wait until it is taken, then maybe pause between bursts
   task automatic send_item(input logic [kpu_pkg::DigitW-1:0] len,
                            input logic [kpu_pkg::RankW-1:0] k);
      kpu_pkg::req_type item;
      int unsigned gap;
      item.perm_length = len;
      item.rank = k;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      unrank_expected(item);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(8, 1);
         // a quarter of the bursts run straight into the next one
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(14, 1);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic test_directed_edges();
      send_item(4'd1, 19'd1);
      send_item(4'd2, 19'd1);
      send_item(4'd2, 19'd2);
      for (int unsigned k = 1; k <= 6; k++) send_item(4'd3, k[kpu_pkg::RankW-1:0]);
      send_item(4'd4, 19'd24);
      send_item(4'd5, 19'd120);
      send_item(4'd8, 19'd40320);
      send_item(4'd9, 19'd1);
      send_item(4'd9, 19'd362880);
   endtask

   task automatic test_error_cases();
      send_item(4'd9, 19'd362881);   // one past n!
      send_item(4'd9, 19'd0);        // rank zero
      send_item(4'd4, 19'd25);
      send_item(4'd0, 19'd1);        // empty length
      send_item(4'd10, 19'd1);       // length above the maximum
      send_item(4'd15, 19'h7FFFF);
   endtask

   task automatic test_random_valid(input int unsigned count);
      int unsigned len;
      int unsigned k;
      for (int unsigned i = 0; i < count; i++) begin
         len = $urandom_range(MaxLen, 1);
         k = $urandom_range(FactOf[len], 1);
         send_item(len[kpu_pkg::DigitW-1:0], k[kpu_pkg::RankW-1:0]);
      end
   endtask

   task automatic test_random_noise(input int unsigned count);
      int unsigned len;
      int unsigned k;
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(2, 0))
            0: begin
               len = $urandom_range(15, 0);
               k = $urandom_range(32'h7FFFF, 0);
            end
            1: begin
               len = $urandom_range(MaxLen, 1);
               k = FactOf[len] + $urandom_range(3, 1);
            end
            default: begin
               len = $urandom_range(15, 0);
               k = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(9, 1);
            end
         endcase
         send_item(len[kpu_pkg::DigitW-1:0], k[kpu_pkg::RankW-1:0]);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected item digit=%0d last=%0b error=%0b",
                                      rsp_data.digit, rsp_data.last, rsp_data.error));
         end else begin
            kpu_pkg::rsp_type want;
            want = pending_digits.pop_front();
            if (rsp_data.digit !== want.digit)
               report_mismatch($sformatf("digit %0d, expected %0d", rsp_data.digit, want.digit));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_data.last, want.last));
            if (rsp_data.error !== want.error)
               report_mismatch($sformatf("error %0b, expected %0b", rsp_data.error, want.error));
         end
      end
   end

   // watchdog on cycles where neither side moves an item
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("[kth_permutation_unrank] ERROR");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_error_cases();
      test_random_valid(300);
      test_random_noise(90);

      start <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && pending_digits.size() == 0) begin
         $display("[kth_permutation_unrank] OK");
      end else begin
         $display("[kth_permutation_unrank] ERROR");
      end
      $finish;
   end

endmodule
